/* rtl/ntci_pkg.sv */
// Package for the thermistor table interpolation unit.
// Holds divider handshake types, field widths and command and register codes.
// No dependencies.
package ntci_pkg;

  // Widths of the stream fields.
  localparam int FieldBits = 12;
  localparam int IndexBits = 8;
  localparam int TempBits  = 17;
  localparam int BaseBits  = 7;

  // Fraction width of the Q8 result and the width of the divider step counter.
  localparam int QBits    = 8;
  localparam int CntBits  = 4;

  // Command codes carried in the input tuser.
  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdConvert = 1'b1;

  // Register index of base_temperature (paddr bit 2) and its reset value.
  localparam logic                RegBaseIdx = 1'b0;
  localparam logic [BaseBits-1:0] BaseReset  = 7'h6C;

  // Request to the fraction divider.
  typedef struct packed {
    logic start;
    logic round_up;
  } div_ctrl_t;

  // Status from the fraction divider.
  typedef struct packed {
    logic             done;
    logic [QBits-1:0] quot;
  } div_stat_t;

endpackage

/* rtl/ntci_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ntci_ram #(
  parameter int Width = 12,
  parameter int Depth = 146
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ntci_div.sv */
// Bit-serial restoring divider for the eight fraction bits of the result.
// Depends on ntci_pkg for the request and status types.
module ntci_div #(
  parameter int Width = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntci_pkg::div_ctrl_t ctrl_i,
  input  logic [Width-1:0]    num_i,
  input  logic [Width-1:0]    den_i,
  output ntci_pkg::div_stat_t stat_o
);

  import ntci_pkg::*;

  logic               busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [Width-1:0]   rem_q, rem_d;
  logic [Width-1:0]   den_q, den_d;
  logic [QBits-1:0]   quo_q, quo_d;
  logic               up_q, up_d;
  logic [Width:0]     shifted;
  logic [Width:0]     diff;
  logic               ge;
  logic               bump;
  logic               done;

  // One quotient bit per cycle; the remainder always stays below the divisor.
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};
  assign done    = busy_q && (cnt_q == '0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    up_d   = up_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(QBits);
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
      up_d   = ctrl_i.round_up;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? diff[Width-1:0] : shifted[Width-1:0];
      quo_d = {quo_q[QBits-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    up_q  <= up_d;
  end

  // Round up on a negative whole part so the result truncates toward zero.
  assign bump        = up_q && (rem_q != '0) && (quo_q != {QBits{1'b1}});
  assign stat_o.done = done;
  assign stat_o.quot = quo_q + QBits'(bump);

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_keep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q != '0) |=> busy_q)
    else $error("divider stopped before its last step");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done)
    else $error("divider done held for more than one cycle");
`endif

endmodule

/* rtl/ntc_table_temperature_interp_unit.sv */
// Channel    | Transfer                | Payload
// s_axis     | load or convert item    | tdata: entry_index, entry_value, sample
// m_axis     | one result per convert  | tdata: temperature_q8; tuser: flags
// apb        | register write / read   | base_temperature at byte address 0
//
// A load item takes one cycle and writes the table RAM at once.
// From its transfer to a valid result, a convert item whose scan stops at index k goes
// through two RAM reads for the clamps, one RAM read per scanned entry, the divider
// and the output register.
// The table RAM has no reset; entries hold their value until loaded again.
// A result waits in the output register while the next item is accepted.
// Top level of the thermistor table temperature interpolation unit.
// Depends on ntci_pkg, ntci_ram and ntci_div.
module ntc_table_temperature_interp_unit #(
  parameter int TABLE_ENTRIES = 146,
  parameter int ADC_BITS      = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] entry_index, [19:8] entry_value, [31:20] sample
  input  logic [31:0] s_axis_tdata,
  // [0] command
  input  logic [0:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [16:0] temperature_q8, [23:17] zero
  output logic [23:0] m_axis_tdata,
  // [0] too_cold, [1] too_hot
  output logic [1:0]  m_axis_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ntci_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] Last = AW'(TABLE_ENTRIES - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_T0   = 3'd1;
  localparam logic [2:0] S_TL   = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [BaseBits-1:0] base_q;
  logic [ADC_BITS-1:0] smp_q, smp_d;
  logic [ADC_BITS-1:0] prev_q, prev_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [9:0]          sum_q, sum_d;
  logic [TempBits-1:0] res_temp_q, res_temp_d;
  logic                res_cold_q, res_cold_d;
  logic                res_hot_q, res_hot_d;
  logic                m_valid_q, m_valid_d;
  logic [TempBits-1:0] m_temp_q;
  logic                m_cold_q, m_hot_q;
  logic                out_load;

  logic                     in_xfer;
  logic                     cmd;
  logic [IndexBits-1:0]     in_index;
  logic [FieldBits-1:0]     in_value;
  logic [FieldBits-1:0]     in_sample;
  logic [FieldBits+ADC_BITS-1:0] value_ext, sample_ext;
  logic [ADC_BITS-1:0]      value_adc, sample_adc;

  logic                we;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [ADC_BITS-1:0] rdata;
  logic [9:0]          base_ext;
  logic [AW-1:0]       lo;
  logic [9:0]          lo_sum;
  logic [9:0]          last_sum;

  div_ctrl_t           div_ctrl;
  div_stat_t           div_stat;
  logic [ADC_BITS-1:0] div_num, div_den;

  // Input unpacking; ADC values are trimmed or widened to ADC_BITS.
  assign cmd        = s_axis_tuser[0];
  assign in_index   = s_axis_tdata[7:0];
  assign in_value   = s_axis_tdata[19:8];
  assign in_sample  = s_axis_tdata[31:20];
  assign value_ext  = {{ADC_BITS{1'b0}}, in_value};
  assign sample_ext = {{ADC_BITS{1'b0}}, in_sample};
  assign value_adc  = value_ext[ADC_BITS-1:0];
  assign sample_adc = sample_ext[ADC_BITS-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Load items below the table size write the RAM directly.
  assign we = in_xfer && (cmd == CmdLoad) && ({1'b0, in_index} < 9'(TABLE_ENTRIES));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegBaseIdx)) begin
      base_q <= pwdata[BaseBits-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegBaseIdx) ? {{(32 - BaseBits){1'b0}}, base_q} : '0;

  // Whole degrees: base plus table index, as a 10-bit two's complement sum.
  assign base_ext = {{(10 - BaseBits){base_q[BaseBits-1]}}, base_q};
  assign lo       = idx_q - 1'b1;
  assign lo_sum   = base_ext + 10'(lo);
  assign last_sum = base_ext + 10'(Last);

  // Table RAM.
  ntci_ram #(
    .Width(ADC_BITS),
    .Depth(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(in_index[AW-1:0]),
    .wdata_i(value_adc),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Fraction divider.
  ntci_div #(
    .Width(ADC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(div_ctrl),
    .num_i (div_num),
    .den_i (div_den),
    .stat_o(div_stat)
  );

  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // Sequencer: clamp checks on the first and last entries, then a scan, a divide and the output hand-off.
  always_comb begin
    state_d           = state_q;
    smp_d             = smp_q;
    prev_d            = prev_q;
    idx_d             = idx_q;
    sum_d             = sum_q;
    res_temp_d        = res_temp_q;
    res_cold_d        = res_cold_q;
    res_hot_d         = res_hot_q;
    re                = 1'b0;
    raddr             = '0;
    div_ctrl.start    = 1'b0;
    div_ctrl.round_up = 1'b0;
    div_num           = prev_q - smp_q;
    div_den           = prev_q - rdata;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (cmd == CmdConvert)) begin
          smp_d   = sample_adc;
          re      = 1'b1;
          raddr   = '0;
          state_d = S_T0;
        end
      end
      S_T0: begin
        if (smp_q >= rdata) begin
          res_temp_d = {base_ext[8:0], {QBits{1'b0}}};
          res_cold_d = 1'b1;
          res_hot_d  = 1'b0;
          state_d    = S_OUT;
        end else begin
          prev_d  = rdata;
          re      = 1'b1;
          raddr   = Last;
          state_d = S_TL;
        end
      end
      S_TL: begin
        if (smp_q <= rdata) begin
          res_temp_d = {last_sum[8:0], {QBits{1'b0}}};
          res_cold_d = 1'b0;
          res_hot_d  = 1'b1;
          state_d    = S_OUT;
        end else begin
          re      = 1'b1;
          raddr   = AW'(1);
          idx_d   = AW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (smp_q > rdata) begin
          sum_d             = lo_sum;
          div_ctrl.start    = 1'b1;
          div_ctrl.round_up = lo_sum[9];
          state_d           = S_DIV;
        end else begin
          prev_d  = rdata;
          re      = 1'b1;
          raddr   = idx_q + 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_temp_d = {sum_q[8:0], div_stat.quot};
          res_cold_d = 1'b0;
          res_hot_d  = 1'b0;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register holds a result until its transfer.
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    prev_q     <= prev_d;
    idx_q      <= idx_d;
    sum_q      <= sum_d;
    res_temp_q <= res_temp_d;
    res_cold_q <= res_cold_d;
    res_hot_q  <= res_hot_d;
    if (out_load) begin
      m_temp_q <= res_temp_q;
      m_cold_q <= res_cold_q;
      m_hot_q  <= res_hot_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(24 - TempBits){1'b0}}, m_temp_q};
  assign m_axis_tuser  = {m_hot_q, m_cold_q};

`ifndef NO_ASSERTIONS
  a_convert_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cmd == CmdConvert) |=> state_q == S_T0)
    else $error("convert transfer did not start the clamp check");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= Last))
    else $error("scan ran past the last table entry");
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");
  a_out_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_valid_q && state_q == S_IDLE))
    else $error("result not handed to the output register");
`endif

endmodule
